>>> rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// Software timer table package
// Shared types and constants for the timer table controller, datapath and
// top level.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Field widths.
  localparam int unsigned TPM_W  = 11;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned IVL_W  = 16;
  localparam int unsigned PROD_W = IVL_W + TPM_W;

  // Command codes.
  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Result kinds.
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FIRED = 1'b1;

  // One request.
  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] now;
    logic [IVL_W-1:0]  period_ms;
    logic              one_shot;
    logic [ID_W-1:0]   target_id;
  } req_t;

  // One result.
  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] timer_id;
    logic            last;
  } rsp_t;

  // One stored timer entry; an interval of zero marks a one-shot timer.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [IVL_W-1:0]  interval;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic do_set;
    logic walk;
    logic finish;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_end;
  } dp_sts_t;

endpackage

>>> rtl/core/stt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/stt_ctrl.sv
// ----------------------------------------------------------------------------
// Software timer table controller
// Sequences set, clear and tick requests and drives the datapath commands.
// ----------------------------------------------------------------------------
module stt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        command_i,
  input  stt_pkg::dp_sts_t  sts_i,
  output stt_pkg::ctl_cmd_t ctl_o,
  output logic              busy_o
);

  import stt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET,
    ST_WALK,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (command_i)
              CMD_SET:             state_q <= ST_SET;
              CMD_CLEAR, CMD_TICK: state_q <= ST_WALK;
              default:             state_q <= ST_IDLE;
            endcase
          end
        end
        ST_SET: begin
          state_q <= ST_IDLE;
        end
        ST_WALK: begin
          if (sts_i.walk_end) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Command decode.
  assign ctl_o.load   = accept;
  assign ctl_o.do_set = (state_q == ST_SET);
  assign ctl_o.walk   = (state_q == ST_WALK);
  assign ctl_o.finish = (state_q == ST_FINISH);
  assign busy_o       = (state_q != ST_IDLE);

  // The finish state at the end of a walk always returns to idle.
  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |=> (state_q == ST_IDLE))
    else $error("finish did not return to idle");

  // A tick request starts a walk.
  a_tick_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_TICK)) |=> (state_q == ST_WALK))
    else $error("tick request did not start a walk");

  // At most one datapath command at a time.
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.load, ctl_o.do_set, ctl_o.walk, ctl_o.finish}))
    else $error("overlapping datapath commands");

endmodule

>>> rtl/core/stt_dp.sv
// ----------------------------------------------------------------------------
// Software timer table datapath
// Entry memory, live bits, counters, deadline arithmetic and result register.
// ----------------------------------------------------------------------------
module stt_dp #(
  parameter int unsigned TIMER_SLOTS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  stt_pkg::ctl_cmd_t          ctl_i,
  output stt_pkg::dp_sts_t           sts_o,
  input  stt_pkg::req_t              req_i,
  input  logic                       cfg_we_i,
  input  logic [stt_pkg::TPM_W-1:0]  cfg_wdata_i,
  output logic                       done_o,
  output stt_pkg::rsp_t              rsp_o
);

  import stt_pkg::*;

  localparam int unsigned AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);

  // Request and configuration.
  req_t             req_q;
  logic [TPM_W-1:0] tpm_q;

  // Table control state.
  logic [CW-1:0]          count_q;
  logic [ID_W-1:0]        id_ctr_q;
  logic [TIMER_SLOTS-1:0] live_q, live_d;

  // Walk state.
  logic [CW-1:0] walk_q;
  logic [CW-1:0] w_q;
  logic          proc_vld_q;
  logic [AW-1:0] proc_idx_q;

  // Pending fired id and the result register.
  logic            pend_vld_q;
  logic [ID_W-1:0] pend_id_q;
  logic            out_vld_q;
  rsp_t            out_q;

  // Combinational signals.
  logic              full;
  logic              issue;
  logic [AW-1:0]     rd_addr;
  entry_t            rd_ent;
  logic [ID_W-1:0]   id_next;
  logic [PROD_W-1:0] set_prod;
  logic [PROD_W-1:0] rearm_prod;
  logic [TIME_W-1:0] set_deadline;
  logic [TIME_W-1:0] rearm_deadline;
  logic              is_tick;
  logic              is_clear;
  logic              ent_live;
  logic              due;
  logic              fire;
  logic              keep;
  logic              clr_hit;
  logic              set_ok;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;

  assign full     = (count_q >= CW'(TIMER_SLOTS));
  assign set_ok   = ctl_i.do_set && !full;
  assign issue    = ctl_i.walk && (walk_q < count_q);
  assign rd_addr  = walk_q[AW-1:0];
  assign id_next  = id_ctr_q + 1'b1;
  assign is_tick  = (req_q.command == CMD_TICK);
  assign is_clear = (req_q.command == CMD_CLEAR);

  // Deadline arithmetic: interval in msec times ticks per msec, plus now.
  assign set_prod       = PROD_W'(req_q.period_ms) * PROD_W'(tpm_q);
  assign rearm_prod     = PROD_W'(rd_ent.interval) * PROD_W'(tpm_q);
  assign set_deadline   = req_q.now + TIME_W'(set_prod);
  assign rearm_deadline = req_q.now + TIME_W'(rearm_prod);

  // Per-entry decisions for the entry read in the previous cycle.
  assign ent_live = live_q[proc_idx_q];
  assign due      = ent_live && (req_q.now >= rd_ent.deadline);
  assign fire     = proc_vld_q && is_tick && due;
  assign keep     = proc_vld_q && is_tick && ent_live &&
                    !(due && (rd_ent.interval == '0));
  assign clr_hit  = proc_vld_q && is_clear && (rd_ent.id == req_q.target_id);

  // Memory write: a new entry on set, or the compacted entry on tick.
  assign ram_we    = set_ok || keep;
  assign ram_waddr = ctl_i.do_set ? count_q[AW-1:0] : w_q[AW-1:0];

  always_comb begin
    if (ctl_i.do_set) begin
      ram_wdata.id       = id_next;
      ram_wdata.deadline = set_deadline;
      ram_wdata.interval = req_q.one_shot ? '0 : req_q.period_ms;
    end else begin
      ram_wdata.id       = rd_ent.id;
      ram_wdata.deadline = due ? rearm_deadline : rd_ent.deadline;
      ram_wdata.interval = rd_ent.interval;
    end
  end

  stt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TIMER_SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_ent)
  );

  // Live bit updates.
  always_comb begin
    live_d = live_q;
    if (set_ok) begin
      live_d[count_q[AW-1:0]] = 1'b1;
    end
    if (clr_hit) begin
      live_d[proc_idx_q] = 1'b0;
    end
    if (keep) begin
      live_d[w_q[AW-1:0]] = 1'b1;
    end
    if (ctl_i.finish && is_tick) begin
      for (int j = 0; j < TIMER_SLOTS; j++) begin
        if (CW'(j) >= w_q) begin
          live_d[j] = 1'b0;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q      <= TPM_W'(1);
      count_q    <= '0;
      id_ctr_q   <= '0;
      live_q     <= '0;
      walk_q     <= '0;
      w_q        <= '0;
      proc_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      out_vld_q  <= 1'b0;
      proc_vld_q <= issue;
      live_q     <= live_d;
      if (cfg_we_i) begin
        tpm_q <= cfg_wdata_i;
      end
      if (ctl_i.load) begin
        walk_q     <= '0;
        w_q        <= '0;
        pend_vld_q <= 1'b0;
      end
      if (issue) begin
        walk_q <= walk_q + 1'b1;
      end
      if (keep) begin
        w_q <= w_q + 1'b1;
      end
      if (ctl_i.do_set) begin
        out_vld_q <= 1'b1;
        if (!full) begin
          id_ctr_q <= id_next;
          count_q  <= count_q + 1'b1;
        end
      end
      if (fire) begin
        pend_vld_q <= 1'b1;
        if (pend_vld_q) begin
          out_vld_q <= 1'b1;
        end
      end
      if (ctl_i.finish && is_tick) begin
        count_q <= w_q;
        if (pend_vld_q) begin
          out_vld_q  <= 1'b1;
          pend_vld_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
    end
    proc_idx_q <= rd_addr;
    if (ctl_i.do_set) begin
      out_q.kind     <= KIND_REPLY;
      out_q.timer_id <= full ? '0 : id_next;
      out_q.last     <= 1'b1;
    end else if (fire) begin
      out_q.kind     <= KIND_FIRED;
      out_q.timer_id <= pend_id_q;
      out_q.last     <= 1'b0;
    end else if (ctl_i.finish) begin
      out_q.kind     <= KIND_FIRED;
      out_q.timer_id <= pend_id_q;
      out_q.last     <= 1'b1;
    end
    if (fire) begin
      pend_id_q <= rd_ent.id;
    end
  end

  assign sts_o.walk_end = (walk_q == count_q);
  assign done_o         = out_vld_q;
  assign rsp_o          = out_q;

  // The table never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TIMER_SLOTS))
    else $error("entry count exceeds table size");

  // Compaction never writes ahead of the entry being processed.
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keep |-> (w_q <= CW'(proc_idx_q)))
    else $error("compaction write index ahead of read index");

  // A set reply is always the only and final result of its request.
  a_reply_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.kind == KIND_REPLY)) |-> out_q.last)
    else $error("set reply without last flag");

endmodule

>>> rtl/core/software_timer_table_top.sv
// ----------------------------------------------------------------------------
// Software timer table
// Up to TIMER_SLOTS software timers in insertion order, with set, clear and
// tick requests and fired-id results.
//
//   Channel   Direction  Signals                    Handshake
//   request   in         start_i, req_i, busy_o     taken when start_i & !busy_o
//   result    out        done_o, rsp_o              one cycle, no back-pressure
//   config    in         cfg_we_i, cfg_wdata_i      written when cfg_we_i
//
// A set request keeps busy_o high for its set state only; its reply is
// registered from that state into the result register.
// Clear and tick requests keep busy_o high through the walk and finish states;
// entry memory is read one entry per cycle, pipelined with its one read port.
// Fired ids wait in a pending register until the next fire, so the last one
// appears in the cycle after the finish state, when busy_o is already low.
// Reset empties the table and sets ticks_per_msec to 1; no clearing pass.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module software_timer_table_top #(
  parameter int unsigned TIMER_SLOTS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  stt_pkg::req_t             req_i,
  output logic                      busy_o,
  output logic                      done_o,
  output stt_pkg::rsp_t             rsp_o,
  input  logic                      cfg_we_i,
  input  logic [stt_pkg::TPM_W-1:0] cfg_wdata_i
);

  import stt_pkg::*;

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  // Request sequencer.
  stt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (req_i.command),
    .sts_i     (sts),
    .ctl_o     (ctl),
    .busy_o    (busy_o)
  );

  // Table storage and arithmetic.
  stt_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule
